@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int PRIO_W    = 8;
  localparam int OCC_W     = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] data;
    logic        [PRIO_W-1:0] prio;
  } spq_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted row: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell (
  input  wire logic                             clk,
  input  wire spq_pkg::spq_ctl_t                ctl,
  input  wire logic                             occ,
  input  wire logic                             left_gt,
  input  wire logic signed [spq_pkg::DATA_W-1:0] left_data,
  input  wire logic        [spq_pkg::PRIO_W-1:0] left_prio,
  input  wire logic signed [spq_pkg::DATA_W-1:0] right_data,
  input  wire logic        [spq_pkg::PRIO_W-1:0] right_prio,
  output logic                                   gt,
  output logic signed [spq_pkg::DATA_W-1:0]      data_r,
  output logic        [spq_pkg::PRIO_W-1:0]      prio_r
);
  import spq_pkg::*;

  // Empty slot or strictly larger priority: the new entry goes at or ahead of here.
  assign gt = !occ || (prio_r > ctl.prio);

  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      if (left_gt) begin
        data_r <= left_data;
        prio_r <= left_prio;
      end else begin
        data_r <= ctl.data;
        prio_r <= ctl.prio;
      end
    end else if (ctl.rem) begin
      data_r <= right_data;
      prio_r <= right_prio;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_priority_queue.sv @@
// Sorted priority queue top level: a row of shifting cells plus count and result register.
// Each result is registered on the clock edge that accepts its item.
// Throughput: 1 item per cycle if out_ready; every cell compares and shifts in parallel.
// Reset: clears the entry count and the result valid; cell contents stay undefined.
`default_nettype none
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_kind,
  input  wire logic signed [spq_pkg::DATA_W-1:0] in_data,
  input  wire logic        [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic             [1:0]                 out_status,
  output logic signed [spq_pkg::DATA_W-1:0]      out_data,
  output logic        [spq_pkg::PRIO_W-1:0]      out_priority,
  output logic        [spq_pkg::OCC_W-1:0]       out_occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r;
  status_t        status_r, status_nxt;
  logic signed [DATA_W-1:0] odata_r, odata_nxt;
  logic [PRIO_W-1:0] oprio_r, oprio_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic           accept, full, empty, is_ins;
  spq_ctl_t       ctl;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic        [PRIO_W-1:0] cell_prio [DEPTH];
  logic                     cell_gt   [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_ins   = (in_kind == KIND_INSERT);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  assign ctl.ins  = accept && is_ins && !full;
  assign ctl.rem  = accept && !is_ins && !empty;
  assign ctl.data = in_data;
  assign ctl.prio = in_priority_req;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     l_gt;
    logic signed [DATA_W-1:0] l_data, r_data;
    logic        [PRIO_W-1:0] l_prio, r_prio;
    logic                     occ;

    if (i == 0) begin : g_head
      assign l_gt   = 1'b0;
      assign l_data = '0;
      assign l_prio = '0;
    end else begin : g_mid
      assign l_gt   = cell_gt[i-1];
      assign l_data = cell_data[i-1];
      assign l_prio = cell_prio[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_data = '0;
      assign r_prio = '0;
    end else begin : g_body
      assign r_data = cell_data[i+1];
      assign r_prio = cell_prio[i+1];
    end
    assign occ = (CW'(i) < count_r);

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .left_gt   (l_gt),
      .left_data (l_data),
      .left_prio (l_prio),
      .right_data(r_data),
      .right_prio(r_prio),
      .gt        (cell_gt[i]),
      .data_r    (cell_data[i]),
      .prio_r    (cell_prio[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    odata_nxt  = '0;
    oprio_nxt  = '0;
    if (is_ins) begin
      if (full) status_nxt = ST_FULL;
      else count_nxt = count_r + CW'(1);
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - CW'(1);
        odata_nxt = cell_data[0];
        oprio_nxt = cell_prio[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      odata_r  <= odata_nxt;
      oprio_r  <= oprio_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data      = odata_r;
  assign out_priority  = oprio_r;
  assign out_occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_DONE) |-> (odata_r == '0 && oprio_r == '0))
    else $error("refused beat carries payload");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_ins && full) |=> (status_r == ST_FULL && count_r == CW'(DEPTH)))
    else $error("insert into full queue changed state");

endmodule
`default_nettype wire

@@ verif/spq_scoreboard_pkg.sv @@
// Result tracking and queue prediction for the sorted priority queue testbench.
package spq_scoreboard_pkg;
  import spq_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic        [PRIO_W-1:0] prio;
    logic        [OCC_W-1:0]  occ;
  } pq_result_t;

  class spq_scoreboard;
    logic signed [DATA_W-1:0] held_data [DEPTH_DEF];
    logic        [PRIO_W-1:0] held_prio [DEPTH_DEF];
    int                       held_count = 0;
    pq_result_t               awaited_results [$];
    int unsigned              mismatches = 0;
    int unsigned              n_insert = 0, n_remove = 0, n_full = 0, n_empty = 0;
    int                       peak_count = 0;

    function int pending();
      return awaited_results.size();
    endfunction

    // Apply one accepted input beat to the shadow queue and queue its result.
    function void note_op(logic kind, logic signed [DATA_W-1:0] data,
                          logic [PRIO_W-1:0] prio);
      pq_result_t r;
      int         slot;
      r = '{status: ST_DONE, data: '0, prio: '0, occ: '0};
      if (kind == KIND_INSERT) begin
        if (held_count >= DEPTH_DEF) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          // goes behind every entry with priority <= its own
          slot = held_count;
          while (slot > 0 && held_prio[slot-1] > prio) slot--;
          for (int i = held_count; i > slot; i--) begin
            held_data[i] = held_data[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_data[slot] = data;
          held_prio[slot] = prio;
          held_count++;
          n_insert++;
          if (held_count > peak_count) peak_count = held_count;
        end
      end else begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.data = held_data[0];
          r.prio = held_prio[0];
          for (int i = 0; i + 1 < held_count; i++) begin
            held_data[i] = held_data[i+1];
            held_prio[i] = held_prio[i+1];
          end
          held_count--;
          n_remove++;
        end
      end
      r.occ = OCC_W'(held_count);
      awaited_results.push_back(r);
    endfunction

    function void check_result(status_t status, logic signed [DATA_W-1:0] data,
                               logic [PRIO_W-1:0] prio, logic [OCC_W-1:0] occ);
      pq_result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing pending: status=%0d data=%0d prio=%0d occ=%0d",
                   $realtime, status, data, prio, occ);
        return;
      end
      want = awaited_results.pop_front();
      if (status !== want.status || data !== want.data || prio !== want.prio ||
          occ !== want.occ) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp st=%0d d=%0d p=%0d occ=%0d, got st=%0d d=%0d p=%0d occ=%0d",
                   $realtime, want.status, want.data, want.prio, want.occ,
                   status, data, prio, occ);
      end
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
// Top-level testbench for the sorted priority queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;
  import spq_scoreboard_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_kind = KIND_INSERT;
  logic signed [DATA_W-1:0] in_data = '0;
  logic        [PRIO_W-1:0] in_priority_req = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic        [1:0]        out_status;
  logic signed [DATA_W-1:0] out_data;
  logic        [PRIO_W-1:0] out_priority;
  logic        [OCC_W-1:0]  out_occupancy;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  spq_scoreboard sb = new();

  logic signed [DATA_W-1:0] fill_data [DEPTH_DEF] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
    32'sh5555_aaaa, 32'shaaaa_5555, 32'sh0000_0001, 32'sh1234_5678,
    32'shfedc_ba98, 32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh0000_0011,
    32'sh0000_0012, 32'sh0000_0013, 32'sh7fff_fffe, 32'sh8000_0001};
  logic [PRIO_W-1:0] fill_prio [DEPTH_DEF] = '{
    8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 8'd1,
    8'd254, 8'd127, 8'd128, 8'd0, 8'd64, 8'd200, 8'd85, 8'd170};

  always #2 clk = ~clk;

  sorted_priority_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_data        (in_data),
    .in_priority_req(in_priority_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data       (out_data),
    .out_priority   (out_priority),
    .out_occupancy  (out_occupancy)
  );

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // input beat is noted before the result check of the same edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_op(in_kind, in_data, in_priority_req);
    if (rst_n && out_valid && out_ready)
      sb.check_result(status_t'(out_status), out_data, out_priority, out_occupancy);
  end

  task automatic send_op(input logic kind, input logic signed [DATA_W-1:0] data,
                         input logic [PRIO_W-1:0] prio);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_data         <= data;
    in_priority_req <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_queue();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // bursts lean toward inserts or removes, or are balanced, so the queue swings between empty and full
  task automatic run_random(input int unsigned ops, input int unsigned idle,
                            input int unsigned stall);
    int unsigned sent, ins_pct, burst, prio_max;
    logic        kind;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < ops) begin
      case ($urandom_range(2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      prio_max = $urandom_range(1) ? 255 : 3;
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        kind = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
        send_op(kind, $urandom, PRIO_W'($urandom_range(prio_max)));
      end
      sent += burst;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty remove, fill with extremes and ties, full insert, two removes
    send_op(KIND_REMOVE, 32'sh7fff_ffff, 8'hff);
    for (int i = 0; i < DEPTH_DEF; i++)
      send_op(KIND_INSERT, fill_data[i], fill_prio[i]);
    send_op(KIND_INSERT, 32'sh1111_1111, 8'd0);
    send_op(KIND_REMOVE, 32'sh8000_0000, 8'h00);
    send_op(KIND_REMOVE, $urandom, 8'h5a);
    drain_queue();

    run_random(330, 0, 0);
    drain_queue();
    run_random(330, 48, 0);
    run_random(330, 0, 48);
    run_random(330, 26, 26);

    drain_queue();
    repeat (4) @(posedge clk);
    $display("Covered %0d inserts, %0d removes, %0d full refusals, %0d empty refusals.",
             sb.n_insert, sb.n_remove, sb.n_full, sb.n_empty);
    $display("Peak occupancy %0d of %0d; %0d result beats disagreed.",
             sb.peak_count, DEPTH_DEF, sb.mismatches);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
